// File: rtl/sedtc_pkg.sv
// ----------------------------------------------------------------------------
// sedtc_pkg
// Shared widths, register map and reset values of the SED trajectory
// compressor.
// ----------------------------------------------------------------------------
package sedtc_pkg;

    // port field widths
    localparam int COORD_PORT_W = 32;
    localparam int TIME_PORT_W  = 32;
    localparam int IDX_W        = 32;
    localparam int SED_W        = 64;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CAP_W      = 7;

    // word index of a register, taken from paddr[2]
    localparam logic [0:0] REG_BUFFER_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

// File: rtl/sedtc_point_if.sv
// ----------------------------------------------------------------------------
// sedtc_point_if / sedtc_result_if
// Valid/ready channels for incoming GPS points and for kept points.
// ----------------------------------------------------------------------------
interface sedtc_point_if import sedtc_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [COORD_PORT_W-1:0] point_lat;
    logic signed [COORD_PORT_W-1:0] point_lon;
    logic        [TIME_PORT_W-1:0]  point_time;
    logic                           last_point;

    modport source (output valid, point_lat, point_lon, point_time, last_point,
                    input ready);
    modport sink   (input valid, point_lat, point_lon, point_time, last_point,
                    output ready);
endinterface

interface sedtc_result_if import sedtc_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [COORD_PORT_W-1:0] out_lat;
    logic signed [COORD_PORT_W-1:0] out_lon;
    logic        [TIME_PORT_W-1:0]  out_time;
    logic        [IDX_W-1:0]        out_index;
    logic                           out_last;

    modport source (output valid, out_lat, out_lon, out_time, out_index, out_last,
                    input ready);
    modport sink   (input valid, out_lat, out_lon, out_time, out_index, out_last,
                    output ready);
endinterface

// File: rtl/sed_buffer_trajectory_compressor.sv
// ----------------------------------------------------------------------------
// sed_buffer_trajectory_compressor
// Online trajectory compressor: buffers points in one RAM, drops the
// interior point of least squared SED when over capacity, flushes on last.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  points    in   valid/ready        point_lat, point_lon, point_time, last_point
//  results   out  valid/ready        out_lat, out_lon, out_time, out_index, out_last
//  apb       in   psel/penable       paddr, pwdata, prdata (buffer_capacity)
//
//  One point at a time. An append accepts the point, then checks the fill;
//  when a SED is computed, RAM reads and the serial divider come between
//  (the divider is skipped when the time span is not positive). Each removal
//  adds a scan, up to two more SED passes and a shift through the single RAM
//  port. At a capacity of two or less a new point overwrites slot 1. A flush
//  waits while a result is stalled. No clearing pass after reset; fill count
//  and point counter reset to zero. A stalled result holds the output register.
// ----------------------------------------------------------------------------
module sed_buffer_trajectory_compressor import sedtc_pkg::*; #(
    parameter int MAX_POINTS      = 64,
    parameter int COORD_BITS      = 32,
    parameter int TIME_BITS       = 32,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sedtc_point_if.sink           points,
    sedtc_result_if.source        results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOTS  = MAX_POINTS + 1;
    localparam int AW     = $clog2(SLOTS);
    localparam int FW     = $clog2(SLOTS + 1);
    localparam int CW     = COORD_BITS;
    localparam int TW     = TIME_BITS;
    localparam int O_SED  = 0;
    localparam int O_IDX  = O_SED + SED_W;
    localparam int O_TIME = O_IDX + IDX_W;
    localparam int O_LON  = O_TIME + TW;
    localparam int O_LAT  = O_LON + CW;
    localparam int RW     = O_LAT + CW;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_SED_RD   = 8'b00000010,
        S_SED_RUN  = 8'b00000100,
        S_CHECK    = 8'b00001000,
        S_SCAN     = 8'b00010000,
        S_SHIFT    = 8'b00100000,
        S_FLUSH_RD = 8'b01000000,
        S_FLUSH_WT = 8'b10000000
    } state_t;

    typedef enum logic [2:0] {
        PH_APPEND = 3'b001,
        PH_REM_A  = 3'b010,
        PH_REM_B  = 3'b100
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [IDX_W-1:0]       pcnt_reg, pcnt_next;
    logic                   last_reg, last_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [FW-1:0]          best_reg, best_next;
    logic [SED_W-1:0]       bsed_reg, bsed_next;
    logic [FW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          sa_reg, sa_next, ma_reg, ma_next, ea_reg, ea_next;
    logic [1:0]             rcnt_reg, rcnt_next;
    logic [RW-1:0]          rows_reg, rows_next, rowm_reg, rowm_next;
    logic                   rdv_reg;
    logic [AW-1:0]          rtag_reg;
    logic                   ovld_reg, ovld_next;
    logic [RW-1:0]          orow_reg, orow_next;
    logic                   olast_reg, olast_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [RW-1:0]          ram_wdata, ram_rdata;
    logic                   su_start, su_done;
    logic [SED_W-1:0]       su_sed;
    logic [FW-1:0]          cap_eff;
    logic                   in_take, issue;
    logic [RW-1:0]          new_row;

    // point storage
    sedtc_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // SED of the middle row against its neighbors
    sedtc_sed_unit #(
        .COORD_BITS      (COORD_BITS),
        .TIME_BITS       (TIME_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_sed (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (su_start),
        .s_lat  (signed'(rows_reg[O_LAT +: CW])),
        .s_lon  (signed'(rows_reg[O_LON +: CW])),
        .s_time (rows_reg[O_TIME +: TW]),
        .m_lat  (signed'(rowm_reg[O_LAT +: CW])),
        .m_lon  (signed'(rowm_reg[O_LON +: CW])),
        .m_time (rowm_reg[O_TIME +: TW]),
        .e_lat  (signed'(ram_rdata[O_LAT +: CW])),
        .e_lon  (signed'(ram_rdata[O_LON +: CW])),
        .e_time (ram_rdata[O_TIME +: TW]),
        .done   (su_done),
        .sed    (su_sed)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_BUFFER_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;

    // clamp capacity to the buffer size
    assign cap_eff = ((CAP_W + 1)'(cap_reg) > (CAP_W + 1)'(MAX_POINTS)) ?
                     FW'(MAX_POINTS) : FW'(cap_reg);

    assign in_take = points.valid && (state_reg == S_IDLE);
    assign new_row = {points.point_lat[CW-1:0], points.point_lon[CW-1:0],
                      points.point_time[TW-1:0], pcnt_reg, SED_W'(0)};

    // sequencer: read, modify, write back
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        pcnt_next  = pcnt_reg;
        last_next  = last_reg;
        best_next  = best_reg;
        bsed_next  = bsed_reg;
        ptr_next   = ptr_reg;
        sa_next    = sa_reg;
        ma_next    = ma_reg;
        ea_next    = ea_reg;
        rcnt_next  = rcnt_reg;
        rows_next  = rows_reg;
        rowm_next  = rowm_reg;
        ovld_next  = ovld_reg && !results.ready;
        orow_next  = orow_reg;
        olast_next = olast_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        su_start   = 1'b0;
        issue      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    pcnt_next = pcnt_reg + IDX_W'(1);
                    last_next = points.last_point;
                    ram_we    = 1'b1;
                    ram_wdata = new_row;
                    if (fill_reg == '0)
                    begin
                        ram_waddr  = '0;
                        fill_next  = FW'(1);
                        state_next = S_CHECK;
                    end
                    else if (cap_eff <= FW'(2))
                    begin
                        ram_waddr  = AW'(1);
                        fill_next  = FW'(2);
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        ram_waddr = AW'(fill_reg);
                        fill_next = fill_reg + FW'(1);
                        if (fill_reg >= FW'(2))
                        begin
                            sa_next    = AW'(fill_reg - FW'(2));
                            ma_next    = AW'(fill_reg - FW'(1));
                            ea_next    = AW'(fill_reg);
                            phase_next = PH_APPEND;
                            rcnt_next  = '0;
                            state_next = S_SED_RD;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end

            S_SED_RD:
            begin
                rcnt_next = rcnt_reg + 2'd1;
                if (rcnt_reg != 2'd3)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = (rcnt_reg == 2'd0) ? sa_reg :
                                (rcnt_reg == 2'd1) ? ma_reg : ea_reg;
                end
                if (rcnt_reg == 2'd1)
                begin
                    rows_next = ram_rdata;
                end
                if (rcnt_reg == 2'd2)
                begin
                    rowm_next = ram_rdata;
                end
                if (rcnt_reg == 2'd3)
                begin
                    su_start   = 1'b1;
                    state_next = S_SED_RUN;
                end
            end

            S_SED_RUN:
            begin
                if (su_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ma_reg;
                    ram_wdata = {rowm_reg[RW-1:O_IDX], su_sed};
                    unique case (phase_reg)
                        PH_APPEND:
                        begin
                            state_next = S_CHECK;
                        end
                        PH_REM_A:
                        begin
                            if ((best_reg + FW'(2)) < fill_reg)
                            begin
                                sa_next    = AW'(best_reg - FW'(1));
                                ma_next    = AW'(best_reg + FW'(1));
                                ea_next    = AW'(best_reg + FW'(2));
                                phase_next = PH_REM_B;
                                rcnt_next  = '0;
                                state_next = S_SED_RD;
                            end
                            else
                            begin
                                ptr_next   = best_reg + FW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        PH_REM_B:
                        begin
                            ptr_next   = best_reg + FW'(1);
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            state_next = S_CHECK;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if ((fill_reg > cap_eff) && (fill_reg >= FW'(3)))
                begin
                    ptr_next   = FW'(1);
                    best_next  = FW'(1);
                    state_next = S_SCAN;
                end
                else if (last_reg)
                begin
                    ptr_next   = '0;
                    state_next = S_FLUSH_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // stream interior SEDs, keep the earliest minimum
                issue = (ptr_reg + FW'(2)) <= fill_reg;
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + FW'(1);
                end
                if (rdv_reg)
                begin
                    if ((rtag_reg == AW'(1)) || (ram_rdata[O_SED +: SED_W] < bsed_reg))
                    begin
                        best_next = FW'(rtag_reg);
                        bsed_next = ram_rdata[O_SED +: SED_W];
                    end
                end
                if (!issue && !rdv_reg)
                begin
                    if (best_reg >= FW'(2))
                    begin
                        sa_next    = AW'(best_reg - FW'(2));
                        ma_next    = AW'(best_reg - FW'(1));
                        ea_next    = AW'(best_reg + FW'(1));
                        phase_next = PH_REM_A;
                        rcnt_next  = '0;
                        state_next = S_SED_RD;
                    end
                    else if ((best_reg + FW'(2)) < fill_reg)
                    begin
                        sa_next    = AW'(best_reg - FW'(1));
                        ma_next    = AW'(best_reg + FW'(1));
                        ea_next    = AW'(best_reg + FW'(2));
                        phase_next = PH_REM_B;
                        rcnt_next  = '0;
                        state_next = S_SED_RD;
                    end
                    else
                    begin
                        ptr_next   = best_reg + FW'(1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // move every row after the dropped one down by one slot
                issue = ptr_reg < fill_reg;
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + FW'(1);
                end
                if (rdv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rtag_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (!issue && !rdv_reg)
                begin
                    fill_next  = fill_reg - FW'(1);
                    state_next = S_CHECK;
                end
            end

            S_FLUSH_RD:
            begin
                if (!ovld_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ptr_reg[AW-1:0];
                    state_next = S_FLUSH_WT;
                end
            end

            S_FLUSH_WT:
            begin
                ovld_next  = 1'b1;
                orow_next  = ram_rdata;
                olast_next = (ptr_reg + FW'(1)) == fill_reg;
                if ((ptr_reg + FW'(1)) == fill_reg)
                begin
                    fill_next  = '0;
                    pcnt_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + FW'(1);
                    state_next = S_FLUSH_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_APPEND;
            fill_reg  <= '0;
            pcnt_reg  <= '0;
            last_reg  <= 1'b0;
            best_reg  <= '0;
            ptr_reg   <= '0;
            rcnt_reg  <= '0;
            rdv_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            pcnt_reg  <= pcnt_next;
            last_reg  <= last_next;
            best_reg  <= best_next;
            ptr_reg   <= ptr_next;
            rcnt_reg  <= rcnt_next;
            rdv_reg   <= ram_re;
            ovld_reg  <= ovld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bsed_reg  <= bsed_next;
        sa_reg    <= sa_next;
        ma_reg    <= ma_next;
        ea_reg    <= ea_next;
        rows_reg  <= rows_next;
        rowm_reg  <= rowm_next;
        rtag_reg  <= ram_raddr;
        orow_reg  <= orow_next;
        olast_reg <= olast_next;
    end

    // channel outputs
    assign points.ready      = (state_reg == S_IDLE);
    assign results.valid     = ovld_reg;
    assign results.out_lat   = COORD_PORT_W'(signed'(orow_reg[O_LAT +: CW]));
    assign results.out_lon   = COORD_PORT_W'(signed'(orow_reg[O_LON +: CW]));
    assign results.out_time  = TIME_PORT_W'(orow_reg[O_TIME +: TW]);
    assign results.out_index = orow_reg[O_IDX +: IDX_W];
    assign results.out_last  = olast_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(SLOTS))
        else $error("fill count beyond slot count");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same slot in one cycle");

    a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovld_reg) |-> $past(state_reg == S_FLUSH_WT))
        else $error("result loaded outside a flush");

    a_sed_expected: assert property (@(posedge clk) disable iff (!rst_n)
        su_done |-> (state_reg == S_SED_RUN))
        else $error("SED result with no pass waiting");

endmodule

// File: rtl/sedtc_ram.sv
// ----------------------------------------------------------------------------
// sedtc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sedtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sedtc_sed_unit.sv
// ----------------------------------------------------------------------------
// sedtc_sed_unit
// Squared synchronous Euclidean distance of a middle point against the
// time interpolation between its neighbors: serial ratio divider, then
// registered multiply, round, square and saturating sum.
// ----------------------------------------------------------------------------
module sedtc_sed_unit import sedtc_pkg::*; #(
    parameter int COORD_BITS      = 32,
    parameter int TIME_BITS       = 32,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] s_lat,
    input  logic signed [COORD_BITS-1:0] s_lon,
    input  logic        [TIME_BITS-1:0]  s_time,
    input  logic signed [COORD_BITS-1:0] m_lat,
    input  logic signed [COORD_BITS-1:0] m_lon,
    input  logic        [TIME_BITS-1:0]  m_time,
    input  logic signed [COORD_BITS-1:0] e_lat,
    input  logic signed [COORD_BITS-1:0] e_lon,
    input  logic        [TIME_BITS-1:0]  e_time,
    output logic                         done,
    output logic        [SED_W-1:0]      sed
);

    localparam int CW  = COORD_BITS;
    localparam int TW  = TIME_BITS;
    localparam int F   = RATIO_FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int KW  = $clog2(QW);
    localparam int DW  = CW + 1;
    localparam int PW  = DW + QW;
    localparam int RW  = CW + 2;
    localparam int EW  = CW + 3;

    typedef enum logic [5:0] {
        SU_IDLE = 6'b000001,
        SU_DIV  = 6'b000010,
        SU_MUL  = 6'b000100,
        SU_RND  = 6'b001000,
        SU_SQ   = 6'b010000,
        SU_SUM  = 6'b100000
    } su_state_t;

    su_state_t               st_reg, st_next;
    logic signed [CW-1:0]    slat_reg, slon_reg, mlat_reg, mlon_reg, elat_reg, elon_reg;
    logic        [TW-1:0]    den_reg;
    logic        [TW:0]      rem_reg;
    logic        [QW-1:0]    q_reg;
    logic        [KW-1:0]    cnt_reg;
    logic        [PW-1:0]    plat_reg, plon_reg;
    logic                    nlat_reg, nlon_reg;
    logic signed [EW-1:0]    dlat_reg, dlon_reg;
    logic        [SED_W-1:0] sqlat_reg, sqlon_reg;
    logic        [SED_W-1:0] sed_reg;
    logic                    done_reg;

    logic signed [TW:0]      num_s, den_s;
    logic        [TW:0]      numc;
    logic                    ge;
    logic        [TW:0]      rem_sub;
    logic signed [DW-1:0]    dl_lat, dl_lon;
    logic        [DW-1:0]    mg_lat, mg_lon;
    logic        [PW-1:0]    rs_lat, rs_lon;
    logic signed [EW-1:0]    off_lat, off_lon;
    logic        [EW-1:0]    am_lat, am_lon;
    logic        [SED_W-1:0] m64_lat, m64_lon;
    logic        [SED_W:0]   sum;

    // time differences and clamped numerator
    always_comb
    begin
        num_s = signed'({1'b0, m_time}) - signed'({1'b0, s_time});
        den_s = signed'({1'b0, e_time}) - signed'({1'b0, s_time});
        if (num_s < 0)
        begin
            numc = '0;
        end
        else if (num_s > den_s)
        begin
            numc = unsigned'(den_s);
        end
        else
        begin
            numc = unsigned'(num_s);
        end
    end

    // one quotient bit per cycle
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // interpolation deltas and their magnitudes
    assign dl_lat = DW'(elat_reg) - DW'(slat_reg);
    assign dl_lon = DW'(elon_reg) - DW'(slon_reg);
    assign mg_lat = dl_lat[DW-1] ? DW'(-dl_lat) : DW'(dl_lat);
    assign mg_lon = dl_lon[DW-1] ? DW'(-dl_lon) : DW'(dl_lon);

    // round half away from zero
    assign rs_lat  = plat_reg + (PW'(1) << (F - 1));
    assign rs_lon  = plon_reg + (PW'(1) << (F - 1));
    assign off_lat = nlat_reg ? -signed'(EW'(rs_lat[F +: RW])) : signed'(EW'(rs_lat[F +: RW]));
    assign off_lon = nlon_reg ? -signed'(EW'(rs_lon[F +: RW])) : signed'(EW'(rs_lon[F +: RW]));

    // magnitudes of the distance components
    assign am_lat  = dlat_reg[EW-1] ? EW'(-dlat_reg) : EW'(dlat_reg);
    assign am_lon  = dlon_reg[EW-1] ? EW'(-dlon_reg) : EW'(dlon_reg);
    assign m64_lat = SED_W'(am_lat);
    assign m64_lon = SED_W'(am_lon);

    assign sum = {1'b0, sqlat_reg} + {1'b0, sqlon_reg};

    // sequence control
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            SU_IDLE:
            begin
                if (start)
                begin
                    st_next = (den_s <= 0) ? SU_MUL : SU_DIV;
                end
            end
            SU_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = SU_MUL;
                end
            end
            SU_MUL:  st_next = SU_RND;
            SU_RND:  st_next = SU_SQ;
            SU_SQ:   st_next = SU_SUM;
            SU_SUM:  st_next = SU_IDLE;
            default: st_next = SU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= SU_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == SU_SUM);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            SU_IDLE:
            begin
                if (start)
                begin
                    slat_reg <= s_lat;
                    slon_reg <= s_lon;
                    mlat_reg <= m_lat;
                    mlon_reg <= m_lon;
                    elat_reg <= e_lat;
                    elon_reg <= e_lon;
                    den_reg  <= den_s[TW-1:0];
                    rem_reg  <= numc;
                    cnt_reg  <= KW'(F);
                    q_reg    <= (den_s <= 0) ? (QW'(1) << F) : '0;
                end
            end
            SU_DIV:
            begin
                q_reg   <= {q_reg[QW-2:0], ge};
                rem_reg <= {rem_sub[TW-1:0], 1'b0};
                cnt_reg <= cnt_reg - KW'(1);
            end
            SU_MUL:
            begin
                plat_reg <= PW'(mg_lat) * PW'(q_reg);
                plon_reg <= PW'(mg_lon) * PW'(q_reg);
                nlat_reg <= dl_lat[DW-1];
                nlon_reg <= dl_lon[DW-1];
            end
            SU_RND:
            begin
                dlat_reg <= EW'(slat_reg) - EW'(mlat_reg) + off_lat;
                dlon_reg <= EW'(slon_reg) - EW'(mlon_reg) + off_lon;
            end
            SU_SQ:
            begin
                sqlat_reg <= (|m64_lat[SED_W-1:32]) ? '1 :
                             SED_W'(m64_lat[31:0]) * SED_W'(m64_lat[31:0]);
                sqlon_reg <= (|m64_lon[SED_W-1:32]) ? '1 :
                             SED_W'(m64_lon[31:0]) * SED_W'(m64_lon[31:0]);
            end
            SU_SUM:
            begin
                sed_reg <= sum[SED_W] ? '1 : sum[SED_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign sed  = sed_reg;

endmodule
